FILE: rtl/core/qrd_pkg.sv
package qrd_pkg;

	localparam int DEF_INDEX_WIDTH  = 24;
	localparam int DEF_SAMPLE_WIDTH = 32;
	localparam int GATE_WIDTH       = 32;
	localparam int MIN_LEN_WIDTH    = 16;

	localparam logic [MIN_LEN_WIDTH-1:0] MIN_LEN_RESET = 16'd10;

	typedef struct packed {
		logic record_start;
		logic gate_on;
	} item_flags_t;

endpackage

FILE: rtl/core/qrd_tracker.sv
module qrd_tracker #(
	parameter int INDEX_WIDTH  = qrd_pkg::DEF_INDEX_WIDTH,
	parameter int SAMPLE_WIDTH = qrd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [qrd_pkg::MIN_LEN_WIDTH-1:0]     cfg_wr_data,
	input  logic                                  fire,
	input  qrd_pkg::item_flags_t                  flags,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	output logic                                  hit,
	output logic [INDEX_WIDTH-1:0]                res_start,
	output logic [INDEX_WIDTH-1:0]                res_end,
	output logic [INDEX_WIDTH-1:0]                res_peak_index,
	output logic signed [SAMPLE_WIDTH-1:0]        res_peak_value
);

	localparam int CMP_WIDTH = (INDEX_WIDTH > qrd_pkg::MIN_LEN_WIDTH) ?
		INDEX_WIDTH : qrd_pkg::MIN_LEN_WIDTH;
	localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

	logic [qrd_pkg::MIN_LEN_WIDTH-1:0] min_len_q;
	logic                              inside_q;
	logic [INDEX_WIDTH-1:0]            index_q;
	logic [INDEX_WIDTH-1:0]            run_start_q;
	logic signed [SAMPLE_WIDTH-1:0]    best_value_q;
	logic [INDEX_WIDTH-1:0]            best_index_q;

	logic                              inside_cur;
	logic [INDEX_WIDTH-1:0]            idx;
	logic [INDEX_WIDTH-1:0]            run_len;
	logic                              inside_nxt;
	logic [INDEX_WIDTH-1:0]            run_start_nxt;
	logic signed [SAMPLE_WIDTH-1:0]    best_value_nxt;
	logic [INDEX_WIDTH-1:0]            best_index_nxt;

	always_comb begin
		inside_cur     = flags.record_start ? 1'b0 : inside_q;
		idx            = flags.record_start ? '0 : index_q;
		run_len        = idx - run_start_q;
		inside_nxt     = inside_cur;
		run_start_nxt  = flags.record_start ? '0 : run_start_q;
		best_value_nxt = flags.record_start ? '0 : best_value_q;
		best_index_nxt = flags.record_start ? '0 : best_index_q;
		hit            = 1'b0;
		if (!inside_cur) begin
			if (flags.gate_on) begin
				inside_nxt     = 1'b1;
				run_start_nxt  = idx;
				best_value_nxt = sample;
				best_index_nxt = idx;
			end
		end else if (flags.gate_on) begin
			if (sample > best_value_q) begin
				best_value_nxt = sample;
				best_index_nxt = idx;
			end
		end else begin
			inside_nxt = 1'b0;
			hit = CMP_WIDTH'(run_len) > CMP_WIDTH'(min_len_q);
		end
	end

	assign res_start      = run_start_q;
	assign res_end        = idx;
	assign res_peak_index = best_index_q;
	assign res_peak_value = best_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q    <= qrd_pkg::MIN_LEN_RESET;
			inside_q     <= 1'b0;
			index_q      <= '0;
			run_start_q  <= '0;
			best_value_q <= '0;
			best_index_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				min_len_q <= cfg_wr_data;
			end
			if (fire) begin
				inside_q     <= inside_nxt;
				index_q      <= (idx == INDEX_MAX) ? INDEX_MAX : idx + 1'b1;
				run_start_q  <= run_start_nxt;
				best_value_q <= best_value_nxt;
				best_index_q <= best_index_nxt;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> (best_index_q >= run_start_q))
		else $error("peak index before run start");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && hit) |=> !inside_q)
		else $error("run still open after reporting a complex");

endmodule

FILE: rtl/core/qrd_out_reg.sv
module qrd_out_reg #(
	parameter int DATA_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [DATA_WIDTH-1:0] load_data,
	output logic                  tvalid,
	input  logic                  tready,
	output logic [DATA_WIDTH-1:0] tdata
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign tvalid = valid_q;
	assign tdata  = data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || tready))
		else $error("result overwritten before its transaction");

endmodule

FILE: rtl/core/qrs_run_and_r_peak_detector_core.sv
// qrs run and r peak detector
// s_axis carries one ecg sample per transaction: tdata holds the gating level
// (nonzero inside a qrs run) and the signed sample searched for the peak,
// tuser flags the first sample of a new record, which restarts the sample
// index at zero and drops any open run.
// m_axis carries one transaction per reported complex: run start index, end
// index (first zero sample after the run), index and value of the first
// maximum. a complex is reported when its length exceeds min_qrs_length,
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// no sample is in flight, and the block does not enforce this. one sample is
// taken per cycle unless a result-bearing sample waits on a stalled m_axis; a
// sample is held in the input register and its result in the output register,
// and run tracking, the length compare and the peak compare are combinational between the two.
// when m_axis stalls with a result waiting, samples that produce no result
// still flow; the next result-bearing sample waits and s_axis_tready drops.
// reset clears all run state, the sample index and both pipeline valids and
// loads min_qrs_length with 10.
module qrs_run_and_r_peak_detector_core #(
	parameter int INDEX_WIDTH  = qrd_pkg::DEF_INDEX_WIDTH,
	parameter int SAMPLE_WIDTH = qrd_pkg::DEF_SAMPLE_WIDTH,
	localparam int IN_DW  = ((qrd_pkg::GATE_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW = ((3 * INDEX_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [qrd_pkg::MIN_LEN_WIDTH-1:0] cfg_wr_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// gate_sample, peak_sample
	input  logic [IN_DW-1:0]                  s_axis_tdata,
	// record_start
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// qrs_start, qrs_end, peak_index, peak_value
	output logic [OUT_DW-1:0]                 m_axis_tdata
);

	localparam int GW = qrd_pkg::GATE_WIDTH;

	logic                           valid_s1;
	qrd_pkg::item_flags_t           flags_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;

	logic                           advance;
	logic                           hit;
	logic [INDEX_WIDTH-1:0]         res_start;
	logic [INDEX_WIDTH-1:0]         res_end;
	logic [INDEX_WIDTH-1:0]         res_peak_index;
	logic signed [SAMPLE_WIDTH-1:0] res_peak_value;
	logic                           in_fire;

	assign advance       = valid_s1 && (!hit || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			flags_s1.record_start <= s_axis_tuser;
			flags_s1.gate_on      <= |s_axis_tdata[GW-1:0];
			sample_s1             <= s_axis_tdata[GW +: SAMPLE_WIDTH];
		end
	end

	qrd_tracker #(
		.INDEX_WIDTH  (INDEX_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.fire           (advance),
		.flags          (flags_s1),
		.sample         (sample_s1),
		.hit            (hit),
		.res_start      (res_start),
		.res_end        (res_end),
		.res_peak_index (res_peak_index),
		.res_peak_value (res_peak_value)
	);

	qrd_out_reg #(
		.DATA_WIDTH (OUT_DW)
	) u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && hit),
		.load_data (OUT_DW'({res_peak_value, res_peak_index, res_end, res_start})),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (m_axis_tdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH] >
			m_axis_tdata[INDEX_WIDTH-1:0]))
		else $error("complex end not after its start");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3*INDEX_WIDTH-1:2*INDEX_WIDTH] >=
			m_axis_tdata[INDEX_WIDTH-1:0] &&
			m_axis_tdata[3*INDEX_WIDTH-1:2*INDEX_WIDTH] <
			m_axis_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH]))
		else $error("peak index outside its complex");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !s_axis_tready)
		else $error("sample taken while the input register is blocked");

endmodule

FILE: dv/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = qrd_pkg::DEF_INDEX_WIDTH;
	localparam int SMP_W = qrd_pkg::DEF_SAMPLE_WIDTH;
	localparam int IN_W = ((qrd_pkg::GATE_WIDTH + SMP_W + 7) / 8) * 8;
	localparam int OUT_W = ((3 * IDX_W + SMP_W + 7) / 8) * 8;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_RUN = 48;

	typedef logic [IDX_W-1:0] index_t;
	typedef logic signed [SMP_W-1:0] sample_t;
	typedef logic [qrd_pkg::GATE_WIDTH-1:0] gate_t;
	typedef logic [qrd_pkg::MIN_LEN_WIDTH-1:0] min_len_t;

	// lowest bits first: qrs_start, qrs_end, peak_index, peak_value
	typedef struct packed {
		sample_t peak_value;
		index_t peak_index;
		index_t qrs_end;
		index_t qrs_start;
	} complex_t;

	localparam sample_t PEAK_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam sample_t PEAK_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	class complex_tracker;
		min_len_t min_len;
		bit in_run;
		index_t next_index;
		index_t run_start;
		index_t best_index;
		sample_t best_value;
		complex_t expected_q[$];
		int errors;

		function new();
			min_len = qrd_pkg::MIN_LEN_RESET;
			in_run = 1'b0;
			next_index = '0;
			run_start = '0;
			best_index = '0;
			best_value = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_sample(bit record_start, gate_t gate, sample_t peak);
			index_t cur;
			complex_t c;
			if (record_start) begin
				next_index = '0;
				in_run = 1'b0;
				run_start = '0;
				best_value = '0;
				best_index = '0;
			end
			cur = next_index;
			if (!in_run) begin
				if (gate != '0) begin
					in_run = 1'b1;
					run_start = cur;
					best_value = peak;
					best_index = cur;
				end
			end else if (gate != '0) begin
				// earliest index wins on ties
				if (peak > best_value) begin
					best_value = peak;
					best_index = cur;
				end
			end else begin
				in_run = 1'b0;
				if (index_t'(cur - run_start) > min_len) begin
					c.qrs_start = run_start;
					c.qrs_end = cur;
					c.peak_index = best_index;
					c.peak_value = best_value;
					expected_q.insert(expected_q.size(), c);
				end
			end
			if (cur != '1)
				next_index = cur + 1'b1;
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %0h, got %0h", field, want, got);
		endfunction

		function void check_result(complex_t got);
			complex_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected complex: start %0d end %0d peak %0d at %0d",
						got.qrs_start, got.qrs_end, got.peak_value, got.peak_index);
				return;
			end
			want = expected_q.pop_front();
			if (got.qrs_start !== want.qrs_start)
				mismatch("qrs_start", want.qrs_start, got.qrs_start);
			if (got.qrs_end !== want.qrs_end)
				mismatch("qrs_end", want.qrs_end, got.qrs_end);
			if (got.peak_index !== want.peak_index)
				mismatch("peak_index", want.peak_index, got.peak_index);
			if (got.peak_value !== want.peak_value)
				mismatch("peak_value", want.peak_value, got.peak_value);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	min_len_t cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	wire s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	wire m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	wire [OUT_W-1:0] m_axis_tdata;

	complex_tracker tracker = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	qrs_run_and_r_peak_detector_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			tracker.check_result(complex_t'(m_axis_tdata));
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("qrs_run_and_r_peak_detector_core test failed");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_sample(bit record_start, gate_t gate, sample_t peak);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= record_start;
		s_axis_tdata <= IN_W'({peak, gate});
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.note_sample(record_start, gate, peak);
		@(negedge clk);
	endtask

	task automatic hold_off();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_min_len(min_len_t value);
		hold_off();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.min_len = value;
	endtask

	function automatic sample_t pick_peak(sample_t prev);
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return prev;
		if (r < 27)
			return PEAK_MAX;
		if (r < 34)
			return PEAK_MIN;
		if (r < 42)
			return sample_t'($urandom_range(8)) - 4;
		return sample_t'($urandom);
	endfunction

	function automatic gate_t pick_gate();
		int r;
		gate_t g;
		r = $urandom_range(99);
		if (r < 40)
			g = $urandom;
		else if (r < 70)
			g = gate_t'(1) << $urandom_range(qrd_pkg::GATE_WIDTH - 1);
		else
			g = $urandom_range(255);
		return (g == '0) ? gate_t'(1) : g;
	endfunction

	// mostly well-formed runs around the configured length, some noise
	task automatic random_traffic(int n_items);
		int sent;
		int r;
		int run_len;
		int lo;
		sample_t prev;
		sent = 0;
		prev = '0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_sample(1'b1, $urandom_range(1) ? pick_gate() : gate_t'(0), pick_peak(prev));
				sent++;
			end else if (r < 15) begin
				send_sample(1'b0, $urandom_range(1) ? pick_gate() : gate_t'(0), $urandom);
				sent++;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_sample(1'b0, '0, $urandom);
					sent++;
				end
				if (tracker.min_len <= 40 && $urandom_range(99) < 75) begin
					lo = (tracker.min_len > 2) ? tracker.min_len - 2 : 1;
					run_len = $urandom_range(lo, tracker.min_len + 3);
				end else begin
					run_len = $urandom_range(1, 12);
				end
				for (int i = 0; i < run_len; i++) begin
					prev = pick_peak(prev);
					send_sample($urandom_range(99) < 2, pick_gate(), prev);
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset length of 10, run of 11 with ties and extremes
		send_sample(1'b1, '0, '0);
		send_sample(1'b0, '1, PEAK_MIN);
		send_sample(1'b0, 1, PEAK_MIN);
		for (int i = 0; i < 7; i++)
			send_sample(1'b0, gate_t'(1) << (4 * i + 2), sample_t'(i * 100 - 300));
		send_sample(1'b0, 32'h8000_0000, PEAK_MAX);
		send_sample(1'b0, 5, PEAK_MAX);
		send_sample(1'b0, '0, PEAK_MAX);

		write_min_len(16'd1);
		send_sample(1'b0, 1, -7);
		send_sample(1'b0, 1, -3);
		send_sample(1'b0, '0, '0);
		send_sample(1'b0, 1, 4);
		send_sample(1'b0, '0, '0);
		// new record drops the open run and starts another at index 0
		send_sample(1'b0, 1, 9);
		send_sample(1'b0, 1, 10);
		send_sample(1'b1, 1, 3);
		send_sample(1'b0, 1, 2);
		send_sample(1'b0, '0, '0);

		write_min_len(16'd0);
		random_traffic(200);

		write_min_len(16'd3);
		send_idle_pct = 77;
		random_traffic(200);

		write_min_len(16'd12);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		random_traffic(250);

		write_min_len(min_len_t'($urandom_range(5, 25)));
		send_idle_pct = 8;
		recv_stall_pct = 8;
		random_traffic(250);

		write_min_len('1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_traffic(100);
		send_sample(1'b0, '0, '0);
		repeat (LONG_RUN) send_sample(1'b0, pick_gate(), $urandom);
		send_sample(1'b0, '0, '0);

		write_min_len(min_len_t'($urandom_range(0, 20)));
		send_idle_pct = 8;
		recv_stall_pct = 77;
		random_traffic(150);
		hold_off();
		random_traffic(150);

		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("qrs_run_and_r_peak_detector_core test passed");
		else
			$display("qrs_run_and_r_peak_detector_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
